>>> rtl/lswc_pkg.sv
package lswc_pkg;

    localparam logic [3:0] CODE_LEFT   = 4'd1;
    localparam logic [3:0] CODE_RIGHT  = 4'd2;
    localparam logic [3:0] CODE_BOTTOM = 4'd4;
    localparam logic [3:0] CODE_TOP    = 4'd8;

    localparam int MAX_MOVES = 4;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

endpackage

>>> rtl/line_segment_window_clipper_core.sv
// Segment clipper against a rectangular window (outcode method).
// The input channel (i_in_valid / o_in_ready) carries one segment per word as
// two signed endpoints. The output channel (o_out_valid / i_out_ready) returns
// one word per segment: the accept flag and the clipped endpoints, which are
// zero when the segment is rejected.
// The user writes the window registers through i_cfg_we, i_cfg_index and
// i_cfg_data only while no segment is in flight; the block does not check.
// Up to four endpoint moves are unrolled into a pipeline. Each move takes
// COORD_WIDTH + 4 stages: setup, multiply, a restoring divider that retires
// two quotient bits per stage, and the final add with saturation.
// Throughput is one word per cycle while the receiver takes results.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_in_ready drops; nothing is lost or repeated.
// Reset empties the pipeline and loads the window with left 50, right 250,
// bottom 50 and top 250.
module line_segment_window_clipper_core
    import lswc_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic signed [COORD_WIDTH-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_accepted,
    output logic signed [COORD_WIDTH-1:0] o_clipped_start_x,
    output logic signed [COORD_WIDTH-1:0] o_clipped_start_y,
    output logic signed [COORD_WIDTH-1:0] o_clipped_end_x,
    output logic signed [COORD_WIDTH-1:0] o_clipped_end_y
);

    localparam int W   = COORD_WIDTH;
    localparam int PW  = 2 * W + 2;
    localparam int NDS = PW / 2;

    typedef struct packed {
        logic                vld;
        logic                done;
        logic                acc;
        logic signed [W-1:0] x1;
        logic signed [W-1:0] y1;
        logic signed [W-1:0] x2;
        logic signed [W-1:0] y2;
        logic [3:0]          c1;
        logic [3:0]          c2;
    } t_seg;

    typedef struct packed {
        t_seg                seg;
        logic                sel;
        logic                axis_y;
        logic                neg;
        logic                dz;
        logic signed [W-1:0] base;
        logic signed [W-1:0] edge_val;
    } t_mov;

    typedef struct packed {
        t_mov       mv;
        logic [W:0] ma;
        logic [W:0] mn;
        logic [W:0] md;
    } t_set;

    typedef struct packed {
        t_mov        mv;
        logic [PW-1:0] prod;
        logic [W:0]  md;
    } t_mul;

    typedef struct packed {
        t_mov          mv;
        logic [W:0]    rem;
        logic [PW-1:0] dvd;
        logic [W:0]    md;
    } t_div;

    logic signed [W-1:0] r_win_left;
    logic signed [W-1:0] r_win_right;
    logic signed [W-1:0] r_win_bottom;
    logic signed [W-1:0] r_win_top;

    t_seg r_seg [MAX_MOVES+1];
    t_set r_set [MAX_MOVES];
    t_mul r_mul [MAX_MOVES];
    t_div r_div [MAX_MOVES][NDS];

    logic                r_out_vld;
    logic                r_out_acc;
    logic signed [W-1:0] r_out_x1;
    logic signed [W-1:0] r_out_y1;
    logic signed [W-1:0] r_out_x2;
    logic signed [W-1:0] r_out_y2;

    logic w_en;
    t_seg n_seg0;

    function automatic logic [3:0] f_outcode(
        input logic signed [W-1:0] x,
        input logic signed [W-1:0] y,
        input logic signed [W-1:0] wl,
        input logic signed [W-1:0] wr,
        input logic signed [W-1:0] wb,
        input logic signed [W-1:0] wt
    );
        logic [3:0] c;
        c = '0;
        if (x < wl) begin
            c = c | CODE_LEFT;
        end else if (x > wr) begin
            c = c | CODE_RIGHT;
        end
        if (y < wb) begin
            c = c | CODE_BOTTOM;
        end else if (y > wt) begin
            c = c | CODE_TOP;
        end
        return c;
    endfunction

    function automatic logic [W:0] f_mag(input logic signed [W:0] v);
        logic [W:0] m;
        m = v[W] ? (W+1)'(-v) : v;
        return m;
    endfunction

    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= W'(50);
            r_win_right  <= W'(250);
            r_win_bottom <= W'(50);
            r_win_top    <= W'(250);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LEFT:   r_win_left   <= i_cfg_data;
                REG_RIGHT:  r_win_right  <= i_cfg_data;
                REG_BOTTOM: r_win_bottom <= i_cfg_data;
                REG_TOP:    r_win_top    <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        n_seg0.vld  = i_in_valid;
        n_seg0.done = 1'b0;
        n_seg0.acc  = 1'b0;
        n_seg0.x1   = i_start_x;
        n_seg0.y1   = i_start_y;
        n_seg0.x2   = i_end_x;
        n_seg0.y2   = i_end_y;
        n_seg0.c1   = f_outcode(i_start_x, i_start_y, r_win_left, r_win_right,
                                r_win_bottom, r_win_top);
        n_seg0.c2   = f_outcode(i_end_x, i_end_y, r_win_left, r_win_right,
                                r_win_bottom, r_win_top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg[0].vld <= 1'b0;
        end else if (w_en) begin
            r_seg[0] <= n_seg0;
        end
    end

    for (genvar m = 0; m < MAX_MOVES; m++) begin : g_move
        t_set n_set;
        t_mul n_mul;
        t_seg n_fin;

        always_comb begin
            t_seg                s;
            logic [3:0]          co;
            logic signed [W:0]   ex1;
            logic signed [W:0]   ey1;
            logic signed [W:0]   ex2;
            logic signed [W:0]   ey2;
            logic signed [W:0]   da;
            logic signed [W:0]   dn;
            logic signed [W:0]   dd;
            s   = r_seg[m];
            ex1 = {s.x1[W-1], s.x1};
            ey1 = {s.y1[W-1], s.y1};
            ex2 = {s.x2[W-1], s.x2};
            ey2 = {s.y2[W-1], s.y2};
            co  = (s.c1 != 4'd0) ? s.c1 : s.c2;
            n_set.mv.seg    = s;
            n_set.mv.sel    = (s.c1 == 4'd0);
            if (!s.done) begin
                if ((s.c1 | s.c2) == 4'd0) begin
                    n_set.mv.seg.done = 1'b1;
                    n_set.mv.seg.acc  = 1'b1;
                end else if ((s.c1 & s.c2) != 4'd0) begin
                    n_set.mv.seg.done = 1'b1;
                end
            end
            priority if ((co & CODE_TOP) != 4'd0) begin
                da = ex2 - ex1;
                dn = {r_win_top[W-1], r_win_top} - ey1;
                dd = ey2 - ey1;
                n_set.mv.axis_y   = 1'b0;
                n_set.mv.base     = s.x1;
                n_set.mv.edge_val = r_win_top;
            end else if ((co & CODE_BOTTOM) != 4'd0) begin
                da = ex2 - ex1;
                dn = {r_win_bottom[W-1], r_win_bottom} - ey1;
                dd = ey2 - ey1;
                n_set.mv.axis_y   = 1'b0;
                n_set.mv.base     = s.x1;
                n_set.mv.edge_val = r_win_bottom;
            end else if ((co & CODE_RIGHT) != 4'd0) begin
                da = ey2 - ey1;
                dn = {r_win_right[W-1], r_win_right} - ex1;
                dd = ex2 - ex1;
                n_set.mv.axis_y   = 1'b1;
                n_set.mv.base     = s.y1;
                n_set.mv.edge_val = r_win_right;
            end else begin
                da = ey2 - ey1;
                dn = {r_win_left[W-1], r_win_left} - ex1;
                dd = ex2 - ex1;
                n_set.mv.axis_y   = 1'b1;
                n_set.mv.base     = s.y1;
                n_set.mv.edge_val = r_win_left;
            end
            n_set.mv.neg = da[W] ^ dn[W] ^ dd[W];
            n_set.mv.dz  = (dd == '0);
            n_set.ma     = f_mag(da);
            n_set.mn     = f_mag(dn);
            n_set.md     = f_mag(dd);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_set[m].mv.seg.vld <= 1'b0;
            end else if (w_en) begin
                r_set[m] <= n_set;
            end
        end

        always_comb begin
            n_mul.mv   = r_set[m].mv;
            n_mul.md   = r_set[m].md;
            n_mul.prod = PW'(r_set[m].ma) * PW'(r_set[m].mn);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mul[m].mv.seg.vld <= 1'b0;
            end else if (w_en) begin
                r_mul[m] <= n_mul;
            end
        end

        for (genvar k = 0; k < NDS; k++) begin : g_div
            t_div d_in;
            t_div n_div;

            if (k == 0) begin : g_first
                always_comb begin
                    d_in.mv  = r_mul[m].mv;
                    d_in.rem = '0;
                    d_in.dvd = r_mul[m].prod;
                    d_in.md  = r_mul[m].md;
                end
            end else begin : g_next
                assign d_in = r_div[m][k-1];
            end

            always_comb begin
                logic [W+1:0]  rt;
                logic [W:0]    rm;
                logic [PW-1:0] dv;
                rm = d_in.rem;
                dv = d_in.dvd;
                for (int b = 0; b < 2; b++) begin
                    rt = {rm, dv[PW-1]};
                    dv = {dv[PW-2:0], 1'b0};
                    if (rt >= {1'b0, d_in.md}) begin
                        rt    = rt - {1'b0, d_in.md};
                        dv[0] = 1'b1;
                    end
                    rm = rt[W:0];
                end
                n_div.mv  = d_in.mv;
                n_div.md  = d_in.md;
                n_div.rem = rm;
                n_div.dvd = dv;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_div[m][k].mv.seg.vld <= 1'b0;
                end else if (w_en) begin
                    r_div[m][k] <= n_div;
                end
            end
        end

        always_comb begin
            t_div                  d;
            logic signed [PW+1:0]  base_e;
            logic signed [PW+1:0]  q_e;
            logic signed [PW+1:0]  res;
            logic signed [W-1:0]   nc;
            logic signed [W-1:0]   nx;
            logic signed [W-1:0]   ny;
            d      = r_div[m][NDS-1];
            base_e = {{(PW+2-W){d.mv.base[W-1]}}, d.mv.base};
            q_e    = {2'b00, d.dvd};
            res    = d.mv.neg ? (base_e - q_e) : (base_e + q_e);
            if (d.mv.dz) begin
                nc = d.mv.base;
            end else if ((res[PW+1:W-1] != '0) && (res[PW+1:W-1] != '1)) begin
                nc = res[PW+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                nc = res[W-1:0];
            end
            nx    = d.mv.axis_y ? d.mv.edge_val : nc;
            ny    = d.mv.axis_y ? nc : d.mv.edge_val;
            n_fin = d.mv.seg;
            if (!d.mv.seg.done) begin
                if (d.mv.sel) begin
                    n_fin.x2 = nx;
                    n_fin.y2 = ny;
                    n_fin.c2 = f_outcode(nx, ny, r_win_left, r_win_right,
                                         r_win_bottom, r_win_top);
                end else begin
                    n_fin.x1 = nx;
                    n_fin.y1 = ny;
                    n_fin.c1 = f_outcode(nx, ny, r_win_left, r_win_right,
                                         r_win_bottom, r_win_top);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_seg[m+1].vld <= 1'b0;
            end else if (w_en) begin
                r_seg[m+1] <= n_fin;
            end
        end
    end

    logic n_out_acc;
    t_seg w_last;

    assign w_last    = r_seg[MAX_MOVES];
    assign n_out_acc = w_last.done ? w_last.acc : ((w_last.c1 | w_last.c2) == 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_last.vld;
            r_out_acc <= n_out_acc;
            r_out_x1  <= n_out_acc ? w_last.x1 : '0;
            r_out_y1  <= n_out_acc ? w_last.y1 : '0;
            r_out_x2  <= n_out_acc ? w_last.x2 : '0;
            r_out_y2  <= n_out_acc ? w_last.y2 : '0;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_accepted        = r_out_acc;
    assign o_clipped_start_x = r_out_x1;
    assign o_clipped_start_y = r_out_y1;
    assign o_clipped_end_x   = r_out_x2;
    assign o_clipped_end_y   = r_out_y2;

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_accepted) |-> ((o_clipped_start_x == '0) &&
        (o_clipped_start_y == '0) && (o_clipped_end_x == '0) && (o_clipped_end_y == '0)))
        else $error("Rejected word carries nonzero coordinates.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("Input stalled without a waiting result.");

    a_entry_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_seg[0].vld)
        else $error("Accepted word did not enter the pipeline.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_seg[MAX_MOVES]) && $stable(r_out_vld)))
        else $error("Pipeline moved during a stall.");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench
    import lswc_pkg::*;
;

    localparam int CW = 16;
    localparam int LATENCY = 4 * (CW + 4) + 2;
    localparam int RANDOM_WORDS = 1050;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic   accepted;
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
    } t_clip_word;

    class t_clip_scoreboard;
        longint win_left, win_right, win_bottom, win_top;
        t_clip_word pending_q[$];
        int errors;

        function new();
            win_left = 50;
            win_right = 250;
            win_bottom = 50;
            win_top = 250;
            errors = 0;
        endfunction

        function void set_window(logic [1:0] idx, t_coord value);
            case (idx)
                REG_LEFT: win_left = value;
                REG_RIGHT: win_right = value;
                REG_BOTTOM: win_bottom = value;
                REG_TOP: win_top = value;
                default: ;
            endcase
        endfunction

        function logic [3:0] region(longint x, longint y);
            logic [3:0] c;
            c = 4'd0;
            if (x < win_left) c |= CODE_LEFT;
            else if (x > win_right) c |= CODE_RIGHT;
            if (y < win_bottom) c |= CODE_BOTTOM;
            else if (y > win_top) c |= CODE_TOP;
            return c;
        endfunction

        function longint edge_cross(longint base, longint da, longint dn, longint dd);
            longint lo, hi, q;
            bit neg;
            lo = -(longint'(1) <<< (CW - 1));
            hi = (longint'(1) <<< (CW - 1)) - 1;
            if (dd == 0) return base;
            neg = ((da < 0) != (dn < 0)) != (dd < 0);
            q = ((da < 0 ? -da : da) * (dn < 0 ? -dn : dn)) / (dd < 0 ? -dd : dd);
            if (neg) return (q > base - lo) ? lo : base - q;
            return (q > hi - base) ? hi : base + q;
        endfunction

        function void note_segment(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
            longint x1, y1, x2, y2, nx, ny;
            logic [3:0] c1, c2, co;
            int moves;
            t_clip_word w;
            x1 = sx; y1 = sy; x2 = ex; y2 = ey;
            c1 = region(x1, y1);
            c2 = region(x2, y2);
            moves = 0;
            w = '0;
            forever begin
                if ((c1 | c2) == 0) begin
                    w.accepted = 1'b1;
                    w.sx = t_coord'(x1); w.sy = t_coord'(y1);
                    w.ex = t_coord'(x2); w.ey = t_coord'(y2);
                    break;
                end
                if ((c1 & c2) != 0 || moves >= MAX_MOVES) break;
                co = (c1 != 0) ? c1 : c2;
                if ((co & CODE_TOP) != 0) begin
                    nx = edge_cross(x1, x2 - x1, win_top - y1, y2 - y1);
                    ny = win_top;
                end else if ((co & CODE_BOTTOM) != 0) begin
                    nx = edge_cross(x1, x2 - x1, win_bottom - y1, y2 - y1);
                    ny = win_bottom;
                end else if ((co & CODE_RIGHT) != 0) begin
                    ny = edge_cross(y1, y2 - y1, win_right - x1, x2 - x1);
                    nx = win_right;
                end else begin
                    ny = edge_cross(y1, y2 - y1, win_left - x1, x2 - x1);
                    nx = win_left;
                end
                if (co == c1) begin
                    x1 = nx; y1 = ny; c1 = region(x1, y1);
                end else begin
                    x2 = nx; y2 = ny; c2 = region(x2, y2);
                end
                moves++;
            end
            pending_q.push_back(w);
        endfunction

        function void check_result(t_clip_word got);
            t_clip_word exp_w;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp_w = pending_q.pop_front();
            if (got.accepted !== exp_w.accepted) begin
                $display("%0t: accepted expected %0d actual %0d", $time,
                         exp_w.accepted, got.accepted);
                errors++;
            end
            if (got.sx !== exp_w.sx) begin
                $display("%0t: start_x expected %0d actual %0d", $time, exp_w.sx, got.sx);
                errors++;
            end
            if (got.sy !== exp_w.sy) begin
                $display("%0t: start_y expected %0d actual %0d", $time, exp_w.sy, got.sy);
                errors++;
            end
            if (got.ex !== exp_w.ex) begin
                $display("%0t: end_x expected %0d actual %0d", $time, exp_w.ex, got.ex);
                errors++;
            end
            if (got.ey !== exp_w.ey) begin
                $display("%0t: end_y expected %0d actual %0d", $time, exp_w.ey, got.ey);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    t_coord i_cfg_data;
    logic i_in_valid, o_in_ready;
    t_coord i_start_x, i_start_y, i_end_x, i_end_y;
    logic o_out_valid, i_out_ready, o_accepted;
    t_coord o_clipped_start_x, o_clipped_start_y, o_clipped_end_x, o_clipped_end_y;

    t_clip_scoreboard board;
    longint cycles;
    bit calm_phase;
    bit hold_off;

    line_segment_window_clipper_core #(.COORD_WIDTH(CW)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result({o_accepted, o_clipped_start_x, o_clipped_start_y,
                                o_clipped_end_x, o_clipped_end_y});
        i_out_ready <= !hold_off && (calm_phase || $urandom_range(99) >= 17);
    end

    task automatic write_window(logic [1:0] idx, t_coord value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        board.set_window(idx, value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_window_all(t_coord l, t_coord r, t_coord b, t_coord t);
        write_window(REG_LEFT, l);
        write_window(REG_RIGHT, r);
        write_window(REG_BOTTOM, b);
        write_window(REG_TOP, t);
    endtask

    task automatic send_segment(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        while (!calm_phase && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x <= ex;
        i_end_y <= ey;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_segment(sx, sy, ex, ey);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic t_coord near_window(longint lo, longint hi);
        longint v;
        v = $urandom_range(0, 3) == 0 ? longint'($signed($urandom_range(65535, 0)) - 32768)
            : lo - 80 + longint'($urandom_range(0, 160)) +
              longint'($urandom_range(0, 1)) * (hi - lo);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return t_coord'(v);
    endfunction

    task automatic random_segments(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_segment(t_coord'($urandom), t_coord'($urandom),
                             t_coord'($urandom), t_coord'($urandom));
            else
                send_segment(near_window(board.win_left, board.win_right),
                             near_window(board.win_bottom, board.win_top),
                             near_window(board.win_left, board.win_right),
                             near_window(board.win_bottom, board.win_top));
        end
    endtask

    initial begin
        board = new();
        calm_phase = 1'b0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_LEFT;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_start_x = '0;
        i_start_y = '0;
        i_end_x = '0;
        i_end_y = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window: inside, trivial reject, one and two moves, corners.
        send_segment(100, 100, 200, 200);
        send_segment(0, 0, 10, 300);
        send_segment(0, 150, 300, 150);
        send_segment(150, 0, 150, 300);
        send_segment(0, 0, 300, 300);
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(32767, -32768, -32768, 32767);
        send_segment(40, 260, 260, 40);
        send_segment(0, 240, 60, 300);
        send_segment(-1, -1, -1, -1);
        send_segment(50, 50, 250, 250);
        send_segment(49, 251, 251, 49);
        drain();

        // Full range window, then an inverted one that forces saturation.
        set_window_all(-32768, 32767, -32768, 32767);
        send_segment(-32768, 32767, 32767, -32768);
        send_segment(-21846, 21845, 0, -1);
        drain();
        set_window_all(300, -300, 200, -200);
        send_segment(0, 0, 1, 1);
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(32767, 0, -32768, 5);
        send_segment(-400, 100, 400, -100);
        send_segment(1000, -32768, -1000, 32767);
        drain();
        set_window_all(0, 0, 0, 0);
        send_segment(-5, -5, 5, 5);
        send_segment(-7, 3, 9, -2);
        drain();

        set_window_all(-1000, 1000, -600, 800);
        random_segments(300);
        calm_phase = 1'b1;
        random_segments(150);
        calm_phase = 1'b0;
        drain();

        set_window_all(50, 250, 50, 250);
        fork
            random_segments(300);
            begin
                hold_off = 1'b1;
                repeat (2 * LATENCY + 100) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        drain();

        set_window_all(200, -100, 150, -150);
        random_segments(300);
        drain();

        if (board.errors == 0 && board.pending_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
